// ===== hw/rtl/atfr_pkg.sv =====
// ----------------------------------------------------------------------------
// AT final result classifier package
// Shared types, constants and character tables for the response line
// classifier and its per-byte parse logic.
// ----------------------------------------------------------------------------
package atfr_pkg;

  // Width of the signed error code range and of the payload field.
  localparam int CODE_BITS = 16;
  localparam int CODE_W    = 16;
  localparam int MAG_W     = CODE_BITS;
  localparam int PROD_W    = MAG_W + 4;

  // Magnitude cap: the largest negative code's magnitude.
  localparam logic [MAG_W-1:0] MAG_CAP   = MAG_W'(1) << (CODE_BITS - 1);
  localparam logic [MAG_W-1:0] MAG_POS_MAX = MAG_CAP - MAG_W'(1);

  // Match position saturates at the top of its four-bit range.
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] POS_MAX    = '1;
  localparam logic [POS_W-1:0] OK_LEN     = POS_W'(2);
  localparam logic [POS_W-1:0] ERR_LEN    = POS_W'(5);
  localparam logic [POS_W-1:0] PREFIX_LEN = POS_W'(11);

  // Bits of the live-pattern mask.
  localparam int PAT_OK     = 0;
  localparam int PAT_ERR    = 1;
  localparam int PAT_CME    = 2;
  localparam int PAT_CMS    = 3;
  localparam int PAT_PROMPT = 4;
  localparam int PAT_N      = 5;

  // Characters with a special role.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_GT    = 8'h3E;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_OK     = 3'd1,
    CLS_ERROR  = 3'd2,
    CLS_CME    = 3'd3,
    CLS_CMS    = 3'd4,
    CLS_PROMPT = 3'd5
  } line_class_t;

  typedef enum logic [1:0] {
    PH_SIGN       = 2'd0,
    PH_AFTER_SIGN = 2'd1,
    PH_DIGITS     = 2'd2,
    PH_DONE       = 2'd3
  } num_phase_t;

  // Line parse state carried from byte to byte.
  typedef struct packed {
    logic               past_blanks;
    logic [POS_W-1:0]   match_pos;
    logic [PAT_N-1:0]   alive;
    logic               term_early;
    num_phase_t         phase;
    logic               negative;
    logic [MAG_W-1:0]   magnitude;
    logic               digit_seen;
  } line_state_t;

  localparam line_state_t STATE_RESET = '{
    past_blanks: 1'b0,
    match_pos:   '0,
    alive:       '1,
    term_early:  1'b0,
    phase:       PH_SIGN,
    negative:    1'b0,
    magnitude:   '0,
    digit_seen:  1'b0
  };

  // Result of one line.
  typedef struct packed {
    line_class_t        line_class;
    logic               code_valid;
    logic [CODE_W-1:0]  error_code;
  } line_result_t;

  // Character of "OK" / "ERROR" at a position.
  function automatic logic [7:0] ok_char(logic [POS_W-1:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h4F; // O
      default: c = 8'h4B; // K
    endcase
    return c;
  endfunction

  function automatic logic [7:0] err_char(logic [POS_W-1:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h45; // E
      4'd1:    c = 8'h52; // R
      4'd2:    c = 8'h52; // R
      4'd3:    c = 8'h4F; // O
      default: c = 8'h52; // R
    endcase
    return c;
  endfunction

  // Character of "+CME ERROR:" or "+CMS ERROR:" at a position.
  function automatic logic [7:0] prefix_char(logic [POS_W-1:0] pos, logic cms);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h2B;              // +
      4'd1:    c = 8'h43;              // C
      4'd2:    c = 8'h4D;              // M
      4'd3:    c = cms ? 8'h53 : 8'h45; // S or E
      4'd4:    c = 8'h20;              // space
      4'd5:    c = 8'h45;              // E
      4'd6:    c = 8'h52;              // R
      4'd7:    c = 8'h52;              // R
      4'd8:    c = 8'h4F;              // O
      4'd9:    c = 8'h52;              // R
      default: c = 8'h3A;              // :
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/atfr_parse.sv =====
// ----------------------------------------------------------------------------
// AT final result classifier: byte step
// Combinational next-state logic for one line byte, plus the line result
// that the updated state gives when the byte ends the line.
// ----------------------------------------------------------------------------
module atfr_parse
  import atfr_pkg::*;
(
  input  line_state_t  state,
  input  logic [7:0]   line_byte,
  output line_state_t  state_next,
  output line_result_t result
);

  logic             is_blank;
  logic             is_space;
  logic             is_digit;
  logic             is_sign;
  logic             in_number;
  logic             take_digit;
  logic [POS_W-1:0] pos;
  logic [PROD_W-1:0] mag_ext;
  logic [PROD_W-1:0] mag_prod;
  logic [MAG_W-1:0]  mag_sat;
  logic [CODE_BITS-1:0] code_full;

  assign pos      = state.match_pos;
  assign is_blank = (line_byte == CH_SP) || (line_byte == CH_CR);
  assign is_space = (line_byte == CH_SP) || (line_byte == CH_TAB) ||
                    (line_byte == CH_LF) || (line_byte == CH_VT) ||
                    (line_byte == CH_FF) || (line_byte == CH_CR);
  assign is_digit = (line_byte >= CH_ZERO) && (line_byte <= CH_NINE);
  assign is_sign  = (line_byte == CH_PLUS) || (line_byte == CH_MINUS);
  assign in_number = (pos >= PREFIX_LEN) &&
                     (state.alive[PAT_CME] || state.alive[PAT_CMS]);

  // Decimal accumulate: m*10 + digit, then clamp to the magnitude cap.
  assign mag_ext  = PROD_W'(state.magnitude);
  assign mag_prod = (mag_ext << 3) + (mag_ext << 1) +
                    PROD_W'(line_byte - CH_ZERO);
  assign mag_sat  = (mag_prod > PROD_W'(MAG_CAP)) ? MAG_CAP : mag_prod[MAG_W-1:0];

  // Digit-or-end step for the sign, after-sign and digit phases.
  always_comb begin
    take_digit = 1'b0;
    unique case (state.phase)
      PH_SIGN:       take_digit = !is_space && !is_sign;
      PH_AFTER_SIGN: take_digit = 1'b1;
      PH_DIGITS:     take_digit = 1'b1;
      PH_DONE:       take_digit = 1'b0;
      default:       take_digit = 1'b0;
    endcase
  end

  // State update for one byte.
  always_comb begin
    state_next = state;
    if (!state.term_early) begin
      if (line_byte == CH_NUL) begin
        state_next.term_early = 1'b1;
      end else if (state.past_blanks || !is_blank) begin
        state_next.past_blanks = 1'b1;
        if (in_number) begin
          if (state.phase == PH_SIGN && is_sign) begin
            state_next.negative = (line_byte == CH_MINUS);
            state_next.phase    = PH_AFTER_SIGN;
          end else if (take_digit) begin
            if (is_digit) begin
              state_next.magnitude  = mag_sat;
              state_next.digit_seen = 1'b1;
              state_next.phase      = PH_DIGITS;
            end else begin
              state_next.phase = PH_DONE;
            end
          end
        end else begin
          // OK: letters, then space or carriage return.
          if (state.alive[PAT_OK]) begin
            if (pos < OK_LEN) begin
              if (line_byte != ok_char(pos)) state_next.alive[PAT_OK] = 1'b0;
            end else if (pos == OK_LEN) begin
              if (!is_blank) state_next.alive[PAT_OK] = 1'b0;
            end
          end
          // ERROR: letters, then space or carriage return.
          if (state.alive[PAT_ERR]) begin
            if (pos < ERR_LEN) begin
              if (line_byte != err_char(pos)) state_next.alive[PAT_ERR] = 1'b0;
            end else if (pos == ERR_LEN) begin
              if (!is_blank) state_next.alive[PAT_ERR] = 1'b0;
            end
          end
          // The two error prefixes.
          if (pos < PREFIX_LEN) begin
            if (state.alive[PAT_CME] && line_byte != prefix_char(pos, 1'b0)) begin
              state_next.alive[PAT_CME] = 1'b0;
            end
            if (state.alive[PAT_CMS] && line_byte != prefix_char(pos, 1'b1)) begin
              state_next.alive[PAT_CMS] = 1'b0;
            end
          end
          // Prompt: '>' followed by a space only.
          if (state.alive[PAT_PROMPT]) begin
            if (pos == '0 && line_byte != CH_GT) begin
              state_next.alive[PAT_PROMPT] = 1'b0;
            end else if (pos == POS_W'(1) && line_byte != CH_SP) begin
              state_next.alive[PAT_PROMPT] = 1'b0;
            end
          end
        end
        if (pos != POS_MAX) state_next.match_pos = pos + POS_W'(1);
      end
    end
  end

  // Signed code from sign and magnitude; positive side clamps one lower.
  always_comb begin
    if (state_next.negative) begin
      code_full = CODE_BITS'('0 - state_next.magnitude);
    end else if (state_next.magnitude > MAG_POS_MAX) begin
      code_full = CODE_BITS'(MAG_POS_MAX);
    end else begin
      code_full = CODE_BITS'(state_next.magnitude);
    end
  end

  // Line class by priority, from the state after this byte.
  always_comb begin
    result = '{line_class: CLS_NONE, code_valid: 1'b0, error_code: '0};
    priority if (state_next.alive[PAT_OK] && state_next.match_pos >= OK_LEN) begin
      result.line_class = CLS_OK;
    end else if (state_next.alive[PAT_ERR] && state_next.match_pos >= ERR_LEN) begin
      result.line_class = CLS_ERROR;
    end else if (state_next.alive[PAT_CME] && state_next.match_pos >= PREFIX_LEN) begin
      result.line_class = CLS_CME;
    end else if (state_next.alive[PAT_CMS] && state_next.match_pos >= PREFIX_LEN) begin
      result.line_class = CLS_CMS;
    end else if (state_next.alive[PAT_PROMPT] && state_next.match_pos >= POS_W'(1)) begin
      result.line_class = CLS_PROMPT;
    end else begin
      result.line_class = CLS_NONE;
    end
    if ((result.line_class == CLS_CME || result.line_class == CLS_CMS) &&
        state_next.digit_seen) begin
      result.code_valid = 1'b1;
      result.error_code = CODE_W'(signed'(code_full));
    end
  end

endmodule

// ===== hw/rtl/at_final_result_line_classifier.sv =====
// ----------------------------------------------------------------------------
// AT final result line classifier
// Classifies one modem response line as OK, ERROR, +CME ERROR, +CMS ERROR or
// prompt, and parses the numeric code of the two error forms.
// ----------------------------------------------------------------------------
// The block takes one character per beat and can accept a beat in every
// clock cycle. Each beat passes through an input register, then one step of
// the parse logic updates the line state; the beat with tlast loads its
// result into the output register as it moves on from the input register. A result
// waits in the output register while later characters keep flowing in; input
// stalls only when the next line end arrives while the previous result has
// not been taken.
// ----------------------------------------------------------------------------
module at_final_result_line_classifier
  import atfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] line_byte
  input  logic        s_tlast,   // line_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] error_code
  output logic [3:0]  m_tuser    // [2:0] line_class, [3] code_valid
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_last;
  logic         advance;
  line_state_t  state;
  line_state_t  state_next;
  line_result_t step_result;
  line_result_t out_result;

  // The staged beat moves on unless it ends a line and the result is blocked.
  assign advance  = in_valid && !(in_last && m_tvalid && !m_tready);
  assign s_tready = !in_valid || advance;

  atfr_parse u_parse (
    .state      (state),
    .line_byte  (in_byte),
    .state_next (state_next),
    .result     (step_result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Line state; cleared after every line end.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= in_last ? STATE_RESET : state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = out_result.error_code;
  assign m_tuser = {out_result.code_valid, out_result.line_class};

endmodule
